>>> rtl/core/isir_pkg.sv
// Shared types and codes for the interval set insert/remove unit.
`timescale 1ns / 1ps
package isir_pkg;

	// Request codes
	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Status codes
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_REVERSED = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_FIND = 9'b000000010,
		S_SPAN = 9'b000000100,
		S_PLAN = 9'b000001000,
		S_SHUP = 9'b000010000,
		S_SHDN = 9'b000100000,
		S_WRT = 9'b001000000,
		S_SUMM = 9'b010000000,
		S_OUT = 9'b100000000
	} state_t;

endpackage

>>> rtl/core/isir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module isir_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/interval_set_insert_remove_unit.sv
// Interval set insert/remove unit: sorted disjoint interval table with add and remove requests.
// Each request walks the stored intervals one entry at a time through a single RAM read
// port, then shifts the tail one entry at a time to open or close a gap, and reads the
// first and last entries for the summary. Walk and shift together touch each stored
// entry about once. Input stall is high while a request is in work or its result waits.
`timescale 1ns / 1ps
module interval_set_insert_remove_unit #(
	parameter int MAX_INTERVALS = 32,
	parameter int VALUE_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic signed [VALUE_WIDTH-1:0] span_low,
	input logic signed [VALUE_WIDTH-1:0] span_high,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic signed [VALUE_WIDTH-1:0] set_low,
	output logic signed [VALUE_WIDTH-1:0] set_high,
	output logic [5:0] interval_count
);

	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int EW = VALUE_WIDTH + 1;
	localparam logic [CW-1:0] MAXC = CW'(MAX_INTERVALS);

	isir_pkg::state_t state_q;
	logic [CW-1:0] used_q, idx_q, i_q, j_q, newn_q;
	logic typ_q, phase_q, k2_q, rd_first_q;
	logic signed [EW-1:0] lo_q, hi_q, ml_q, mh_q, n0l_q, n0h_q, n1l_q, n1h_q;
	logic signed [EW-1:0] firstl_q, lasth_q;
	logic [1:0] st_q;
	logic [1:0] k_q;

	// RAM port
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [2*VALUE_WIDTH-1:0] wdata, rdata;
	logic signed [EW-1:0] rl, rh;

	isir_ram #(.WIDTH(2 * VALUE_WIDTH), .DEPTH(MAX_INTERVALS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign rl = EW'($signed(rdata[2*VALUE_WIDTH-1:VALUE_WIDTH]));
	assign rh = EW'($signed(rdata[VALUE_WIDTH-1:0]));
	assign in_stall = (state_q != isir_pkg::S_IDLE);

	// Single shared compare: extended-width value against bound
	logic signed [EW-1:0] cmp_a, cmp_b;
	logic cmp_lt;
	assign cmp_lt = cmp_a < cmp_b;

	always_comb begin
		cmp_a = rh;
		cmp_b = lo_q;
		if (state_q == isir_pkg::S_FIND) begin
			cmp_a = typ_q ? rh : rh + EW'(1);
			cmp_b = lo_q;
		end else begin
			cmp_a = typ_q ? hi_q : hi_q + EW'(1);
			cmp_b = rl;
		end
	end

	// RAM address and write data
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = idx_q[AW-1:0];
		if (state_q == isir_pkg::S_SHUP) begin
			// read the entry below idx, write it on the next cycle
			if (phase_q) begin
				we = 1'b1;
				waddr = AW'(idx_q + CW'(k_q) - (j_q - i_q));
				wdata = rdata;
			end else begin
				raddr = AW'(idx_q - CW'(1));
			end
		end else if (state_q == isir_pkg::S_SHDN && phase_q) begin
			we = 1'b1;
			waddr = AW'(idx_q + CW'(k_q) - (j_q - i_q));
			wdata = rdata;
		end else if (state_q == isir_pkg::S_WRT) begin
			we = 1'b1;
			waddr = AW'(i_q + CW'(rd_first_q));
			wdata = rd_first_q ? {n1l_q[VALUE_WIDTH-1:0], n1h_q[VALUE_WIDTH-1:0]}
				: {n0l_q[VALUE_WIDTH-1:0], n0h_q[VALUE_WIDTH-1:0]};
		end
		if (state_q == isir_pkg::S_SUMM) begin
			raddr = rd_first_q ? AW'(newn_q - CW'(1)) : '0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isir_pkg::S_IDLE;
			used_q <= '0;
			out_valid <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				isir_pkg::S_IDLE: begin
					if (in_valid) begin
						typ_q <= req_type;
						lo_q <= EW'(span_low);
						hi_q <= EW'(span_high);
						ml_q <= EW'(span_low);
						mh_q <= EW'(span_high);
						idx_q <= '0;
						phase_q <= 1'b0;
						newn_q <= used_q;
						if (span_low > span_high) begin
							st_q <= isir_pkg::ST_REVERSED;
							state_q <= isir_pkg::S_SUMM;
							rd_first_q <= 1'b0;
						end else if (req_type == isir_pkg::REQ_ADD && used_q >= MAXC) begin
							st_q <= isir_pkg::ST_FULL;
							state_q <= isir_pkg::S_SUMM;
							rd_first_q <= 1'b0;
						end else begin
							st_q <= isir_pkg::ST_DONE;
							state_q <= isir_pkg::S_FIND;
						end
					end
				end
				isir_pkg::S_FIND: begin
					// phase 0 issues read, phase 1 compares
					if (!phase_q) begin
						if (idx_q >= used_q) begin
							i_q <= idx_q;
							j_q <= idx_q;
							state_q <= isir_pkg::S_PLAN;
						end else begin
							phase_q <= 1'b1;
						end
					end else begin
						phase_q <= 1'b0;
						if (cmp_lt) begin
							idx_q <= idx_q + CW'(1);
						end else begin
							i_q <= idx_q;
							firstl_q <= rl;
							state_q <= isir_pkg::S_SPAN;
						end
					end
				end
				isir_pkg::S_SPAN: begin
					if (!phase_q) begin
						if (idx_q >= used_q) begin
							j_q <= idx_q;
							state_q <= isir_pkg::S_PLAN;
						end else begin
							phase_q <= 1'b1;
						end
					end else begin
						phase_q <= 1'b0;
						if (!cmp_lt) begin
							if (rl < ml_q) ml_q <= rl;
							if (rh > mh_q) mh_q <= rh;
							lasth_q <= rh;
							idx_q <= idx_q + CW'(1);
						end else begin
							j_q <= idx_q;
							state_q <= isir_pkg::S_PLAN;
						end
					end
				end
				isir_pkg::S_PLAN: begin
					// Decide replacement entries and shift direction, or refuse a split that would overflow
					phase_q <= 1'b0;
					rd_first_q <= 1'b0;
					if (typ_q == isir_pkg::REQ_ADD) begin
						k_q <= 2'd1;
						k2_q <= 1'b0;
						n0l_q <= (j_q != i_q && firstl_q < ml_q) ? firstl_q : ml_q;
						n0h_q <= mh_q;
						newn_q <= used_q - (j_q - i_q) + CW'(1);
						if (j_q == i_q) begin
							idx_q <= used_q;
							state_q <= isir_pkg::S_SHUP;
						end else begin
							idx_q <= j_q;
							state_q <= isir_pkg::S_SHDN;
						end
					end else if (j_q == i_q) begin
						state_q <= isir_pkg::S_SUMM;
					end else begin
						logic a, b;
						a = firstl_q < lo_q;
						b = lasth_q > hi_q;
						k_q <= 2'(a) + 2'(b);
						k2_q <= a & b;
						n0l_q <= a ? firstl_q : hi_q + EW'(1);
						n0h_q <= a ? lo_q - EW'(1) : lasth_q;
						n1l_q <= hi_q + EW'(1);
						n1h_q <= lasth_q;
						if ({1'b0, used_q} - {1'b0, j_q - i_q} + (CW + 1)'(2'(a) + 2'(b))
								> {1'b0, MAXC}) begin
							st_q <= isir_pkg::ST_FULL;
							state_q <= isir_pkg::S_SUMM;
						end else begin
							newn_q <= used_q - (j_q - i_q) + CW'(2'(a) + 2'(b));
							if (CW'(2'(a) + 2'(b)) > j_q - i_q) begin
								idx_q <= used_q;
								state_q <= isir_pkg::S_SHUP;
							end else begin
								idx_q <= j_q;
								state_q <= isir_pkg::S_SHDN;
							end
						end
					end
				end
				isir_pkg::S_SHUP: begin
					// Move tail up, last entry first
					if (!phase_q) begin
						if (idx_q <= j_q) begin
							state_q <= (k_q == 2'd0) ? isir_pkg::S_SUMM : isir_pkg::S_WRT;
						end else begin
							idx_q <= idx_q - CW'(1);
							phase_q <= 1'b1;
						end
					end else begin
						phase_q <= 1'b0;
					end
				end
				isir_pkg::S_SHDN: begin
					// Move tail down, first entry first
					if (!phase_q) begin
						if (idx_q >= used_q) begin
							state_q <= (k_q == 2'd0) ? isir_pkg::S_SUMM : isir_pkg::S_WRT;
						end else begin
							phase_q <= 1'b1;
						end
					end else begin
						phase_q <= 1'b0;
						idx_q <= idx_q + CW'(1);
					end
				end
				isir_pkg::S_WRT: begin
					if (k2_q && !rd_first_q) begin
						rd_first_q <= 1'b1;
					end else begin
						rd_first_q <= 1'b0;
						state_q <= isir_pkg::S_SUMM;
					end
				end
				isir_pkg::S_SUMM: begin
					// read entry 0, take its low, then take entry n-1's high
					if (!rd_first_q) begin
						rd_first_q <= 1'b1;
					end else if (!phase_q) begin
						set_low <= (newn_q == '0) ? '0 : rl[VALUE_WIDTH-1:0];
						phase_q <= 1'b1;
					end else begin
						set_high <= (newn_q == '0) ? '0 : rh[VALUE_WIDTH-1:0];
						rd_first_q <= 1'b0;
						phase_q <= 1'b0;
						state_q <= isir_pkg::S_OUT;
						used_q <= newn_q;
						out_valid <= 1'b1;
						status <= st_q;
						interval_count <= 6'(newn_q);
					end
				end
				isir_pkg::S_OUT: begin
					if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
						state_q <= isir_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= isir_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/isir_checker.sv
// Port-level checker for the interval set insert/remove unit, bound to the top level.
`timescale 1ns / 1ps
module isir_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] status,
	input logic [5:0] interval_count
);

	// One request in work at a time: no input transfer while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");

	// After an input transfer the unit is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("not busy after input transfer");

	// Status is one of the defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3)) else $error("undefined status");

	// Count never above 32 with the default table size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (interval_count <= 6'd32)) else $error("count out of range");

	// A held result stays valid and its status does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result changed while stalled");

endmodule

bind interval_set_insert_remove_unit isir_checker u_isir_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.interval_count(interval_count)
);

>>> tb/tb_top.sv
// Testbench for the interval set insert/remove unit: directed and random requests against a predictor.
`timescale 1ns / 1ps
module tb_top;

	localparam int MAXI = 32;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		isir_pkg::status_t st;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [5:0] cnt;
	} summary_t;

	logic clk, arst_n;
	logic in_valid, in_stall, req_type;
	logic signed [31:0] span_low, span_high;
	logic out_valid, out_stall;
	logic [1:0] status;
	logic signed [31:0] set_low, set_high;
	logic [5:0] interval_count;

	// Predictor state
	longint tab_lo[MAXI];
	longint tab_hi[MAXI];
	int tab_n;
	summary_t expected_q[$];
	int errors, sent, checked, full_seen, split_seen;
	int cycles;
	bit hold_rx;

	interval_set_insert_remove_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .span_low(span_low), .span_high(span_high),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .set_low(set_low), .set_high(set_high),
		.interval_count(interval_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Replace entries [at, at+gone) with k new entries
	function automatic void table_splice(int at, int gone, int k, longint nl[2], longint nh[2]);
		longint cl[MAXI];
		longint ch[MAXI];
		int m;
		m = 0;
		for (int t = 0; t < at; t++) begin
			cl[m] = tab_lo[t]; ch[m] = tab_hi[t]; m++;
		end
		for (int t = 0; t < k; t++) begin
			cl[m] = nl[t]; ch[m] = nh[t]; m++;
		end
		for (int t = at + gone; t < tab_n; t++) begin
			cl[m] = tab_lo[t]; ch[m] = tab_hi[t]; m++;
		end
		tab_lo = cl;
		tab_hi = ch;
		tab_n = m;
	endfunction

	function automatic summary_t predict_set(logic op, logic signed [31:0] a, logic signed [31:0] b);
		summary_t r;
		longint lo, hi, ml, mh;
		longint nl[2], nh[2];
		int i, j, k;
		lo = a;
		hi = b;
		r.st = isir_pkg::ST_DONE;
		if (lo > hi) begin
			r.st = isir_pkg::ST_REVERSED;
		end else if (op == isir_pkg::REQ_ADD) begin
			if (tab_n >= MAXI) begin
				r.st = isir_pkg::ST_FULL;
			end else begin
				i = 0;
				while (i < tab_n && tab_hi[i] + 1 < lo) i++;
				j = i; ml = lo; mh = hi;
				while (j < tab_n && tab_lo[j] <= hi + 1) begin
					if (tab_lo[j] < ml) ml = tab_lo[j];
					if (tab_hi[j] > mh) mh = tab_hi[j];
					j++;
				end
				nl[0] = ml; nh[0] = mh;
				table_splice(i, j - i, 1, nl, nh);
			end
		end else begin
			i = 0; k = 0;
			while (i < tab_n && tab_hi[i] < lo) i++;
			j = i;
			while (j < tab_n && tab_lo[j] <= hi) j++;
			if (j != i) begin
				if (tab_lo[i] < lo) begin
					nl[k] = tab_lo[i]; nh[k] = lo - 1; k++;
				end
				if (tab_hi[j-1] > hi) begin
					nl[k] = hi + 1; nh[k] = tab_hi[j-1]; k++;
				end
				if (tab_n - (j - i) + k > MAXI) begin
					r.st = isir_pkg::ST_FULL;
					split_seen++;
				end else begin
					table_splice(i, j - i, k, nl, nh);
				end
			end
		end
		if (r.st == isir_pkg::ST_FULL) full_seen++;
		r.cnt = tab_n[5:0];
		r.lo = tab_n ? 32'(tab_lo[0]) : '0;
		r.hi = tab_n ? 32'(tab_hi[tab_n-1]) : '0;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
	endtask

	// Send one request, with a random gap before it
	task automatic send_request(logic op, logic signed [31:0] a, logic signed [31:0] b);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		span_low <= a;
		span_high <= b;
		expected_q.push_back(predict_set(op, a, b));
		sent++;
		do @(posedge clk); while (in_stall);
	endtask

	// Result check at each transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			summary_t e;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				e = expected_q.pop_front();
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (set_low !== e.lo) report_mismatch("set_low", set_low, e.lo);
				if (set_high !== e.hi) report_mismatch("set_high", set_high, e.hi);
				if (interval_count !== e.cnt)
					report_mismatch("interval_count", interval_count, e.cnt);
			end
			checked++;
		end
	end

	// Receiver stall pattern
	always @(posedge clk) begin
		if (hold_rx) out_stall <= 1'b1;
		else if ($urandom_range(0, 3) == 0) out_stall <= 1'b0;
		else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
		else if ($urandom_range(0, 2) == 0) out_stall <= ($urandom_range(0, 1) == 1);
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic signed [31:0] rnd_val(int spread);
		int unsigned u;
		u = $urandom;
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff - $urandom_range(0, 3);
			1: return 32'sh80000000 + $urandom_range(0, 3);
			2: return u;
			default: return $signed($urandom_range(0, spread)) - spread / 2;
		endcase
	endfunction

	task automatic test_directed();
		send_request(isir_pkg::REQ_ADD, 10, 5);
		send_request(isir_pkg::REQ_REMOVE, 3, 2);
		send_request(isir_pkg::REQ_REMOVE, 0, 100);
		send_request(isir_pkg::REQ_ADD, 32'sh80000000, 32'sh80000000);
		send_request(isir_pkg::REQ_ADD, 32'sh7fffffff, 32'sh7fffffff);
		send_request(isir_pkg::REQ_ADD, 32'sh7ffffffe, 32'sh7ffffffe);
		send_request(isir_pkg::REQ_ADD, 32'sh80000001, 32'sh80000002);
		send_request(isir_pkg::REQ_ADD, 10, 20);
		send_request(isir_pkg::REQ_ADD, 22, 30);
		send_request(isir_pkg::REQ_ADD, 21, 21);
		send_request(isir_pkg::REQ_REMOVE, 15, 16);
		send_request(isir_pkg::REQ_REMOVE, 14, 17);
		send_request(isir_pkg::REQ_REMOVE, 0, 14);
		send_request(isir_pkg::REQ_REMOVE, 32'sh80000000, 32'sh7fffffff);
		send_request(isir_pkg::REQ_ADD, 32'sh80000000, 32'sh7fffffff);
		send_request(isir_pkg::REQ_REMOVE, 1, 0);
		send_request(isir_pkg::REQ_REMOVE, 32'sh80000000, 32'sh7fffffff);
	endtask

	// Fill the table, then hit both full cases
	task automatic test_full_table();
		for (int t = 0; t < MAXI; t++) send_request(isir_pkg::REQ_ADD, t * 10, t * 10 + 5);
		send_request(isir_pkg::REQ_ADD, 1000, 1001);
		send_request(isir_pkg::REQ_ADD, 6, 6);
		send_request(isir_pkg::REQ_REMOVE, 2, 3);
		send_request(isir_pkg::REQ_REMOVE, 0, 5);
		send_request(isir_pkg::REQ_REMOVE, 12, 13);
		send_request(isir_pkg::REQ_REMOVE, 32'sh80000000, 32'sh7fffffff);
	endtask

	// Long receiver hold while requests keep coming
	task automatic test_backpressure();
		hold_rx = 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_rx = 1'b0;
			end
			for (int t = 0; t < 8; t++) send_request(isir_pkg::REQ_ADD, t * 4, t * 4 + 1);
		join
	endtask

	task automatic test_random(int count);
		int spread;
		for (int t = 0; t < count; t++) begin
			spread = ($urandom_range(0, 3) == 0) ? 4000 : 300;
			if ($urandom_range(0, 19) == 0) begin
				send_request(1'($urandom_range(0, 1)), rnd_val(spread), rnd_val(spread));
			end else begin
				logic signed [31:0] a;
				a = rnd_val(spread);
				send_request(($urandom_range(0, 9) < 6) ? isir_pkg::REQ_ADD : isir_pkg::REQ_REMOVE,
					a, ($urandom_range(0, 9) == 0) ? rnd_val(spread) :
					a + $urandom_range(0, 12));
			end
		end
	endtask

	initial begin
		errors = 0; sent = 0; checked = 0; full_seen = 0; split_seen = 0; cycles = 0;
		tab_n = 0; hold_rx = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0; req_type = isir_pkg::REQ_ADD; span_low = '0; span_high = '0;
		out_stall = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random(2000);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d requests, %0d results checked, %0d full refusals (%0d on split)",
			sent, checked, full_seen, split_seen);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule
